FILE: sv/dtc_pkg.sv
package dtc_pkg;

   localparam int DAYS_W = 16;

   localparam logic [31:0] SECS_PER_DAY  = 32'd86400;
   localparam logic [31:0] SECS_PER_HOUR = 32'd3600;
   localparam logic [31:0] SECS_PER_MIN  = 32'd60;

   // reciprocals for the constant divides:
   // (secs >> 7) / 675 = ((secs >> 7) * DAY_RECIP) >> 35
   // tod / 3600 = (tod * HOUR_RECIP) >> 29, rem / 60 = (rem * MIN_RECIP) >> 18
   localparam logic [25:0] DAY_RECIP  = 26'd50903317;
   localparam logic [17:0] HOUR_RECIP = 18'd149131;
   localparam logic [12:0] MIN_RECIP  = 13'd4370;

   localparam logic [11:0] BASE_YEAR        = 12'd1970;
   localparam logic [8:0]  BASE_YEAR_MOD400 = 9'd370;
   localparam logic [8:0]  MOD400_LAST      = 9'd399;
   localparam logic [8:0]  CENTURY_1        = 9'd100;
   localparam logic [8:0]  CENTURY_2        = 9'd200;
   localparam logic [8:0]  CENTURY_3        = 9'd300;
   localparam logic [8:0]  DAYS_PER_YEAR    = 9'd365;
   localparam logic [8:0]  DAYS_PER_LEAP    = 9'd366;

   localparam logic [3:0] MONTH_JAN  = 4'd0;
   localparam logic [3:0] MONTH_FEB  = 4'd1;
   localparam logic [3:0] MONTH_APR  = 4'd3;
   localparam logic [3:0] MONTH_JUN  = 4'd5;
   localparam logic [3:0] MONTH_SEP  = 4'd8;
   localparam logic [3:0] MONTH_NOV  = 4'd10;
   localparam logic [3:0] MONTH_LAST = 4'd11;

   typedef struct packed {
      logic [31:0] epoch_seconds;
   } req_payload_type;

   typedef struct packed {
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  mday;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second_of_minute;
   } rsp_payload_type;

   // split time, handed from the divider to the calendar walk
   typedef struct packed {
      logic [DAYS_W-1:0] days;
      logic [4:0]        hour;
      logic [5:0]        minute;
      logic [5:0]        second;
   } work_type;

   function automatic logic [4:0] month_days(input logic [3:0] mo, input logic leap);
      logic [4:0] len;
      case (mo)
         MONTH_FEB: len = leap ? 5'd29 : 5'd28;
         MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
         default: len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

FILE: sv/dtc_chan_if.sv
interface dtc_chan_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

FILE: sv/dtc_front.sv
module dtc_front (
   input  logic              clock,
   input  logic              reset,
   dtc_chan_if.sink          req_chan,
   output logic              push_valid,
   input  logic              push_ready,
   output dtc_pkg::work_type push_entry
);
   import dtc_pkg::*;

   typedef enum logic [4:0] {
      F_IDLE = 5'b00001,
      F_DAY  = 5'b00010,
      F_HOUR = 5'b00100,
      F_MIN  = 5'b01000,
      F_PUSH = 5'b10000
   } front_state_type;

   front_state_type   state_ff, state_in;
   logic [31:0]       rem_ff, rem_in;
   logic [DAYS_W-1:0] quo_ff, quo_in;
   logic              step_ff, step_in;
   logic [DAYS_W-1:0] days_ff, days_in;
   logic [4:0]        hour_ff, hour_in;
   logic [5:0]        minute_ff, minute_in;

   logic [50:0]       day_prod;
   logic [33:0]       hour_prod;
   logic [23:0]       min_prod;
   logic [DAYS_W-1:0] quo_est;
   logic [31:0]       quo_back;

   // quotient by reciprocal multiply; 86400 = 128 * 675, so days come from secs >> 7
   assign day_prod  = 51'(rem_ff[31:7]) * 51'(DAY_RECIP);
   assign hour_prod = 34'(rem_ff[16:0]) * 34'(HOUR_RECIP);
   assign min_prod  = 24'(rem_ff[11:0]) * 24'(MIN_RECIP);

   // each phase takes the quotient first, then the remainder
   always_comb begin
      case (state_ff)
         F_DAY: begin
            quo_est  = day_prod[50:35];
            quo_back = 32'(quo_ff) * SECS_PER_DAY;
         end
         F_HOUR: begin
            quo_est  = DAYS_W'(hour_prod[33:29]);
            quo_back = 32'(quo_ff) * SECS_PER_HOUR;
         end
         default: begin
            quo_est  = DAYS_W'(min_prod[23:18]);
            quo_back = 32'(quo_ff) * SECS_PER_MIN;
         end
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      step_in   = step_ff;
      days_in   = days_ff;
      hour_in   = hour_ff;
      minute_in = minute_ff;
      case (state_ff)
         F_IDLE: begin
            if (req_chan.valid) begin
               rem_in   = req_chan.payload.epoch_seconds;
               step_in  = 1'b0;
               state_in = F_DAY;
            end
         end
         F_DAY, F_HOUR, F_MIN: begin
            if (!step_ff) begin
               quo_in  = quo_est;
               step_in = 1'b1;
            end else begin
               rem_in  = rem_ff - quo_back;
               step_in = 1'b0;
               case (state_ff)
                  F_DAY: begin
                     days_in  = quo_ff;
                     state_in = F_HOUR;
                  end
                  F_HOUR: begin
                     hour_in  = quo_ff[4:0];
                     state_in = F_MIN;
                  end
                  default: begin
                     minute_in = quo_ff[5:0];
                     state_in  = F_PUSH;
                  end
               endcase
            end
         end
         F_PUSH: begin
            if (push_ready) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      step_ff   <= step_in;
      days_ff   <= days_in;
      hour_ff   <= hour_in;
      minute_ff <= minute_in;
   end

   assign req_chan.ready    = (state_ff == F_IDLE);
   assign push_valid        = (state_ff == F_PUSH);
   assign push_entry.days   = days_ff;
   assign push_entry.hour   = hour_ff;
   assign push_entry.minute = minute_ff;
   assign push_entry.second = rem_ff[5:0];

endmodule

FILE: sv/dtc_queue.sv
module dtc_queue #(
   parameter int DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  dtc_pkg::work_type push_entry,
   output logic              pop_valid,
   input  logic              pop_ready,
   output dtc_pkg::work_type pop_entry
);
   import dtc_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   work_type        entries_ff [DEPTH];
   logic [AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_push, do_pop;

   assign push_ready = (count_ff != CW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;
   assign pop_entry  = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

FILE: sv/dtc_back.sv
module dtc_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              pop_valid,
   output logic              pop_ready,
   input  dtc_pkg::work_type pop_entry,
   dtc_chan_if.source        rsp_chan
);
   import dtc_pkg::*;

   typedef enum logic [3:0] {
      B_IDLE  = 4'b0001,
      B_YEAR  = 4'b0010,
      B_MONTH = 4'b0100,
      B_DONE  = 4'b1000
   } back_state_type;

   back_state_type    state_ff, state_in;
   logic [DAYS_W-1:0] days_ff, days_in;
   logic [11:0]       year_ff, year_in;
   logic [8:0]        ymod_ff, ymod_in;
   logic [3:0]        mo_ff, mo_in;
   logic              leap_ff, leap_in;
   logic [4:0]        hour_ff, hour_in;
   logic [5:0]        minute_ff, minute_in;
   logic [5:0]        second_ff, second_in;
   logic              out_valid_ff, out_valid_in;
   rsp_payload_type   out_ff, out_in;

   logic              leap_now;
   logic [8:0]        ylen;
   logic [4:0]        mlen;
   logic              out_free;

   // Gregorian rule on the year counted modulo 400
   assign leap_now = (ymod_ff[1:0] == 2'd0) && (ymod_ff != CENTURY_1)
                     && (ymod_ff != CENTURY_2) && (ymod_ff != CENTURY_3);
   assign ylen     = leap_now ? DAYS_PER_LEAP : DAYS_PER_YEAR;
   assign mlen     = month_days(mo_ff, leap_ff);
   assign out_free = !out_valid_ff || rsp_chan.ready;

   always_comb begin
      state_in     = state_ff;
      days_in      = days_ff;
      year_in      = year_ff;
      ymod_in      = ymod_ff;
      mo_in        = mo_ff;
      leap_in      = leap_ff;
      hour_in      = hour_ff;
      minute_in    = minute_ff;
      second_in    = second_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      pop_ready    = 1'b0;
      case (state_ff)
         B_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               days_in   = pop_entry.days;
               hour_in   = pop_entry.hour;
               minute_in = pop_entry.minute;
               second_in = pop_entry.second;
               year_in   = BASE_YEAR;
               ymod_in   = BASE_YEAR_MOD400;
               state_in  = B_YEAR;
            end
         end
         B_YEAR: begin
            if (days_ff < DAYS_W'(ylen)) begin
               leap_in  = leap_now;
               mo_in    = MONTH_JAN;
               state_in = B_MONTH;
            end else begin
               days_in = days_ff - DAYS_W'(ylen);
               year_in = year_ff + 12'd1;
               ymod_in = (ymod_ff == MOD400_LAST) ? 9'd0 : ymod_ff + 9'd1;
            end
         end
         B_MONTH: begin
            if ((mo_ff == MONTH_LAST) || (days_ff < DAYS_W'(mlen))) begin
               state_in = B_DONE;
            end else begin
               days_in = days_ff - DAYS_W'(mlen);
               mo_in   = mo_ff + 4'd1;
            end
         end
         B_DONE: begin
            if (out_free) begin
               out_in.year             = year_ff;
               out_in.month            = mo_ff + 4'd1;
               out_in.mday             = days_ff[4:0] + 5'd1;
               out_in.hour             = hour_ff;
               out_in.minute           = minute_ff;
               out_in.second_of_minute = second_ff;
               out_valid_in            = 1'b1;
               state_in                = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      days_ff   <= days_in;
      year_ff   <= year_in;
      ymod_ff   <= ymod_in;
      mo_ff     <= mo_in;
      leap_ff   <= leap_in;
      hour_ff   <= hour_in;
      minute_ff <= minute_in;
      second_ff <= second_in;
      out_ff    <= out_in;
   end

   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.payload = out_ff;

endmodule

FILE: sv/epoch_seconds_to_datetime.sv
// Seconds since 1970-01-01 00:00:00 in, calendar date and time of day out.
// req_chan carries one 32-bit epoch_seconds per beat; rsp_chan returns one
// beat per request with year, month, mday, hour, minute and
// second_of_minute. Both are valid/ready; a beat moves when both are high.
// The front splits the seconds into days, hours, minutes and seconds by
// reciprocal multiplication, each quotient and then its remainder, and
// takes a new request only after it hands over the last one (accept,
// divide by day, hour and minute, hand-over). A queue of QUEUE_DEPTH
// entries then feeds the calendar walk, one year per cycle and then one
// month per cycle; the front works ahead on the next request while the
// walk runs.
// A stalled rsp_chan holds its beat in the output register; the walk
// waits, the queue fills, the front holds its finished request and
// req_chan.ready stays low.
// Synchronous reset empties the queue and returns both parts to idle.
module epoch_seconds_to_datetime #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   dtc_chan_if.sink    req_chan,
   dtc_chan_if.source  rsp_chan
);
   import dtc_pkg::*;

   logic     push_valid, push_ready;
   logic     pop_valid, pop_ready;
   work_type push_entry, pop_entry;

   dtc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   dtc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   dtc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_entry (pop_entry),
      .rsp_chan  (rsp_chan)
   );

endmodule

FILE: test/tb_epoch_seconds_to_datetime.sv
module tb_epoch_seconds_to_datetime;
   import dtc_pkg::*;

   localparam int unsigned DAY_SECS  = 86400;
   localparam int unsigned HOUR_SECS = 3600;
   localparam int unsigned MIN_SECS  = 60;
   localparam int unsigned FIRST_YEAR = 1970;
   localparam int LIMIT_CYCLES = 1000000;
   localparam int HOLD_CYCLES  = 400;
   localparam int TAIL_CYCLES  = 250;
   localparam int PHASE_ITEMS  = 132;

   logic clock;
   logic reset;

   dtc_chan_if #(.payload_type(req_payload_type)) req_chan ();
   dtc_chan_if #(.payload_type(rsp_payload_type)) rsp_chan ();

   epoch_seconds_to_datetime dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   req_payload_type pending_epochs[$];
   rsp_payload_type due_datetimes[$];
   logic [31:0]     directed_epochs[$];

   int send_gap_pct   = 0;
   int recv_stall_pct = 0;
   int hold_left      = 0;
   int holds_asked    = 0;
   int holds_served   = 0;
   int cycle_count    = 0;
   int sent_count     = 0;
   int checked_count  = 0;
   int mismatch_count = 0;

   initial begin
      clock = 1'b0;
   end

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---- calendar predictor ----

   function automatic bit leap_year(int unsigned y);
      return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
   endfunction

   function automatic int unsigned year_length(int unsigned y);
      return leap_year(y) ? 366 : 365;
   endfunction

   function automatic int unsigned month_length(int unsigned m, bit leap);
      int unsigned len;
      case (m)
         2: len = leap ? 29 : 28;
         4, 6, 9, 11: len = 30;
         default: len = 31;
      endcase
      return len;
   endfunction

   // seconds at 1 January 00:00:00 of year y
   function automatic longint unsigned year_start(int unsigned y);
      longint unsigned total;
      total = 0;
      for (int unsigned k = FIRST_YEAR; k < y; k++)
         total += longint'(year_length(k)) * DAY_SECS;
      return total;
   endfunction

   function automatic rsp_payload_type to_datetime(logic [31:0] secs);
      rsp_payload_type dt;
      int unsigned day_count, tod, yr, mo, mlen;
      day_count = secs / DAY_SECS;
      tod       = secs % DAY_SECS;
      yr        = FIRST_YEAR;
      while (day_count >= year_length(yr)) begin
         day_count -= year_length(yr);
         yr++;
      end
      mo = 1;
      while (mo < 12) begin
         mlen = month_length(mo, leap_year(yr));
         if (day_count < mlen)
            break;
         day_count -= mlen;
         mo++;
      end
      dt.year             = yr[11:0];
      dt.month            = mo[3:0];
      dt.mday             = 5'(day_count + 1);
      dt.hour             = 5'(tod / HOUR_SECS);
      dt.minute           = 6'((tod % HOUR_SECS) / MIN_SECS);
      dt.second_of_minute = 6'(tod % MIN_SECS);
      return dt;
   endfunction

   // random epoch, biased towards day, year and leap-day edges
   function automatic logic [31:0] pick_epoch();
      longint unsigned v;
      int unsigned y;
      case ($urandom_range(0, 9))
         4, 5: begin
            v = longint'($urandom_range(0, 49709)) * DAY_SECS;
            v += $urandom_range(0, 1) ? $urandom_range(0, 3)
                                      : DAY_SECS - 1 - $urandom_range(0, 3);
         end
         6: begin
            y = $urandom_range(1971, 2106);
            v = year_start(y) - 4 + $urandom_range(0, 7);
         end
         7: begin
            // leap candidates, 2100 among them
            y = 1972 + 4 * $urandom_range(0, 33);
            v = year_start(y) + longint'($urandom_range(57, 60)) * DAY_SECS
                + $urandom_range(0, DAY_SECS - 1);
         end
         8: v = $urandom_range(0, 126230400);
         9: v = $urandom_range(32'hF000_0000, 32'hFFFF_FFFF);
         default: v = $urandom;
      endcase
      if (v > 64'hFFFF_FFFF)
         v = $urandom;
      return v[31:0];
   endfunction

   // ---- driver ----

   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid   <= 1'b0;
         req_chan.payload <= '0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            due_datetimes.push_back(to_datetime(req_chan.payload.epoch_seconds));
            sent_count++;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (pending_epochs.size() > 0 && $urandom_range(0, 99) >= send_gap_pct) begin
               req_chan.valid   <= 1'b1;
               req_chan.payload <= pending_epochs.pop_front();
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // ---- long receiver hold-off ----

   always @(posedge clock) begin
      if (reset) begin
         hold_left    <= 0;
         holds_served <= 0;
      end else if (holds_served != holds_asked) begin
         hold_left    <= HOLD_CYCLES;
         holds_served <= holds_asked;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // ---- monitor ----

   always @(posedge clock) begin : monitor
      rsp_payload_type want, got;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got = rsp_chan.payload;
            if (due_datetimes.size() == 0) begin
               if (mismatch_count < 10)
                  $display("Unexpected result beat: %0d-%0d-%0d %0d:%0d:%0d",
                           got.year, got.month, got.mday,
                           got.hour, got.minute, got.second_of_minute);
               mismatch_count++;
            end else begin
               want = due_datetimes.pop_front();
               if (got.year !== want.year || got.month !== want.month ||
                   got.mday !== want.mday || got.hour !== want.hour ||
                   got.minute !== want.minute ||
                   got.second_of_minute !== want.second_of_minute) begin
                  if (mismatch_count < 10)
                     $display({"Mismatch on beat %0d: want %0d-%0d-%0d %0d:%0d:%0d,",
                               " got %0d-%0d-%0d %0d:%0d:%0d"},
                              checked_count, want.year, want.month, want.mday,
                              want.hour, want.minute, want.second_of_minute,
                              got.year, got.month, got.mday,
                              got.hour, got.minute, got.second_of_minute);
                  mismatch_count++;
               end
               checked_count++;
            end
         end
         rsp_chan.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // ---- watchdog ----

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("Timed out after %0d cycles, %0d results outstanding",
                  cycle_count, due_datetimes.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   // ---- stimulus ----

   task automatic wait_drained();
      while (pending_epochs.size() > 0 || req_chan.valid || due_datetimes.size() > 0)
         @(posedge clock);
   endtask

   task automatic run_phase(int gap_pct, int stall_pct, int count, bit with_hold);
      @(posedge clock);
      send_gap_pct   <= gap_pct;
      recv_stall_pct <= stall_pct;
      if (with_hold)
         holds_asked <= holds_asked + 1;
      repeat (count)
         pending_epochs.push_back('{epoch_seconds: pick_epoch()});
      wait_drained();
   endtask

   initial begin
      reset            = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.payload = '0;
      rsp_chan.ready   = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      directed_epochs = '{
         32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
         32'(year_start(1971) - 1), 32'(year_start(1971)),
         32'(year_start(1972) + 59 * DAY_SECS), 32'(year_start(1973) - 1),
         32'(year_start(1999) + 334 * DAY_SECS),
         32'(year_start(2000) + 59 * DAY_SECS), 32'(year_start(2001) - 1),
         32'(year_start(2100) + 59 * DAY_SECS - 1), 32'(year_start(2100) + 59 * DAY_SECS),
         32'(year_start(2101) - 1),
         32'h7FFF_FFFF, 32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA,
         32'hFFFF_FFFE, 32'hFFFF_FFFF
      };
      foreach (directed_epochs[i])
         pending_epochs.push_back('{epoch_seconds: directed_epochs[i]});
      wait_drained();

      // no idling, but the sink holds off at the start so the block backs up
      run_phase(0, 0, PHASE_ITEMS, 1'b1);
      run_phase(45, 0, PHASE_ITEMS, 1'b0);
      run_phase(0, 45, PHASE_ITEMS, 1'b0);
      run_phase(8, 8, PHASE_ITEMS, 1'b0);

      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Converted %0d epoch values (%0d checked) across directed edges",
               sent_count, checked_count);
      $display("and four traffic phases: leap days, the 2100 non-leap century,",
               " the 32-bit top and a long sink stall.");
      if (mismatch_count == 0 && due_datetimes.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("%0d mismatches, %0d results never arrived",
                  mismatch_count, due_datetimes.size());
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

FILE: sim.f
sv/dtc_pkg.sv
sv/dtc_chan_if.sv
sv/dtc_front.sv
sv/dtc_queue.sv
sv/dtc_back.sv
sv/epoch_seconds_to_datetime.sv
test/tb_epoch_seconds_to_datetime.sv
